FILE: sv/se3pj_pkg.sv
// ----------------------------------------------------------------------------
// se3pj_pkg: shared types and constants of the SE(3) projection Jacobian core
// Lane numbering of the ten Jacobian entries, register indexes and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package se3pj_pkg;

  // Number of Jacobian entries computed side by side.
  localparam int unsigned NUM_LANES = 10;

  // Quotient bits produced by the divider pipeline.
  localparam int unsigned QUO_BITS = 32;

  // Configuration register indexes.
  localparam logic REG_FOCAL_X = 1'b0;
  localparam logic REG_FOCAL_Y = 1'b1;

  // Reset value of both focal lengths: 500.0 in Q16.16.
  localparam logic [31:0] FOCAL_RESET = 32'd32768000;

  // One in Q16.16.
  localparam logic [63:0] Q16_ONE = 64'h0000_0000_0001_0000;

  // Lane of each entry; lanes below LANE_V_TY use focal_x.
  localparam int unsigned LANE_U_TX = 0;
  localparam int unsigned LANE_U_TZ = 1;
  localparam int unsigned LANE_U_RX = 2;
  localparam int unsigned LANE_U_RY = 3;
  localparam int unsigned LANE_U_RZ = 4;
  localparam int unsigned LANE_V_TY = 5;
  localparam int unsigned LANE_V_TZ = 6;
  localparam int unsigned LANE_V_RX = 7;
  localparam int unsigned LANE_V_RY = 8;
  localparam int unsigned LANE_V_RZ = 9;

  // Saturation limits of a signed 32-bit code.
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef logic [63:0] word64_t;
  typedef logic [95:0] word96_t;
  typedef logic [31:0] word32_t;

endpackage

`default_nettype wire

FILE: sv/se3_projection_jacobian_core.sv
// ----------------------------------------------------------------------------
// se3_projection_jacobian_core: SE(3) point projection Jacobian
// Per-pixel point store and a fully pipelined 2x6 projection Jacobian unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): func_i=0 stores point_x/y/z at
//   pixel_col_i, pixel_row_i (ignored outside the image); func_i=1 reads the
//   stored point and produces one result transaction. A store produces none.
//   Output channel (out_valid_o / out_stall_i): valid_res_o and the ten
//   Jacobian entries, Q16.16, saturated; zero with valid_res_o=0 for a depth
//   of zero or less or a pixel outside the image.
//   Configuration channel (cfg_valid_i / cfg_ready_o): focal_x at index 0 and
//   focal_y at index 1; the user must write them only while the core is idle,
//   as the core does not enforce it. Throughput: one transaction per cycle
//   while the receiver does not stall. The divider is a restoring divider,
//   one quotient bit per stage, with its own datapath in each of the ten lanes.
//   A store is visible to a Jacobian transaction accepted in the next cycle.
//   Reset clears the pipeline valid bits and loads 500.0 into both focal
//   lengths; point store contents are undefined until written.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall_o rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module se3_projection_jacobian_core
  import se3pj_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = 64,
  parameter int unsigned IMAGE_HEIGHT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [5:0]  pixel_col_i,
  input  wire logic [5:0]  pixel_row_i,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] point_z_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             valid_res_o,
  output logic [31:0]      j_u_tx_o,
  output logic [31:0]      j_u_tz_o,
  output logic [31:0]      j_u_rx_o,
  output logic [31:0]      j_u_ry_o,
  output logic [31:0]      j_u_rz_o,
  output logic [31:0]      j_v_ty_o,
  output logic [31:0]      j_v_tz_o,
  output logic [31:0]      j_v_rx_o,
  output logic [31:0]      j_v_ry_o,
  output logic [31:0]      j_v_rz_o,
  // Configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned CELLS = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);

  // Global pipeline advance: hold everything while a result waits.
  logic en;
  logic in_accept;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign in_accept   = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  // Focal length registers.
  logic [31:0] focal_x_q, focal_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= FOCAL_RESET;
      focal_y_q <= FOCAL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FOCAL_X: focal_x_q <= cfg_data_i;
        REG_FOCAL_Y: focal_y_q <= cfg_data_i;
        default:     focal_x_q <= focal_x_q;
      endcase
    end
  end

  // Pixel address and image bounds check.
  logic [23:0]   lin_addr;
  logic [AW-1:0] addr;
  logic          in_image;

  assign lin_addr = 24'(pixel_row_i) * 24'(IMAGE_WIDTH) + 24'(pixel_col_i);
  assign addr     = lin_addr[AW-1:0];
  assign in_image = (32'(pixel_col_i) < IMAGE_WIDTH) && (32'(pixel_row_i) < IMAGE_HEIGHT);

  // Point store: one {x, y, z} word per pixel, registered read.
  logic [95:0] mem [CELLS];
  logic [95:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_accept && !func_i && in_image) begin
      mem[addr] <= {point_x_i, point_y_i, point_z_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= mem[addr];
    end
  end

  // Stage 1: memory read.
  logic v1_q, in1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_accept && func_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in1_q <= in_image;
    end
  end

  // Stage 2: magnitudes and signs.
  logic [31:0] x1, y1, z1;
  logic        v2_q, ok2_q, xneg2_q, yneg2_q, xpos2_q, ypos2_q;
  logic [31:0] ax2_q, ay2_q, zu2_q;

  assign x1 = rd_q[95:64];
  assign y1 = rd_q[63:32];
  assign z1 = rd_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok2_q   <= in1_q && !z1[31] && (z1 != '0);
      xneg2_q <= x1[31];
      yneg2_q <= y1[31];
      xpos2_q <= !x1[31] && (x1 != '0);
      ypos2_q <= !y1[31] && (y1 != '0);
      ax2_q   <= x1[31] ? 32'(-x1) : x1;
      ay2_q   <= y1[31] ? 32'(-y1) : y1;
      zu2_q   <= z1;
    end
  end

  // Stage 3: squares and cross product.
  logic        v3_q, ok3_q, xneg3_q, yneg3_q, xpos3_q, ypos3_q;
  logic [31:0] ax3_q, ay3_q, zu3_q;
  word64_t     zz3_q, xx3_q, xy3_q, yy3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok3_q   <= ok2_q;
      xneg3_q <= xneg2_q;
      yneg3_q <= yneg2_q;
      xpos3_q <= xpos2_q;
      ypos3_q <= ypos2_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      zu3_q   <= zu2_q;
      zz3_q   <= 64'(zu2_q) * 64'(zu2_q);
      xx3_q   <= 64'(ax2_q) * 64'(ax2_q);
      xy3_q   <= 64'(ax2_q) * 64'(ay2_q);
      yy3_q   <= 64'(ay2_q) * 64'(ay2_q);
    end
  end

  // Stage 4: numerators, divisors and signs of each lane.
  logic    v4_q, ok4_q;
  word64_t m4_q [NUM_LANES];
  word64_t d4_q [NUM_LANES];
  logic    n4_q [NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok4_q <= ok3_q;
      m4_q[LANE_U_TX] <= Q16_ONE;
      m4_q[LANE_U_TZ] <= {ax3_q, 16'd0} & 64'h0000_FFFF_FFFF_FFFF;
      m4_q[LANE_U_RX] <= xy3_q;
      m4_q[LANE_U_RY] <= zz3_q + xx3_q;
      m4_q[LANE_U_RZ] <= 64'(ay3_q);
      m4_q[LANE_V_TY] <= Q16_ONE;
      m4_q[LANE_V_TZ] <= {16'd0, ay3_q, 16'd0};
      m4_q[LANE_V_RX] <= zz3_q + yy3_q;
      m4_q[LANE_V_RY] <= xy3_q;
      m4_q[LANE_V_RZ] <= 64'(ax3_q);
      d4_q[LANE_U_TX] <= 64'(zu3_q);
      d4_q[LANE_U_TZ] <= zz3_q;
      d4_q[LANE_U_RX] <= zz3_q;
      d4_q[LANE_U_RY] <= zz3_q;
      d4_q[LANE_U_RZ] <= 64'(zu3_q);
      d4_q[LANE_V_TY] <= 64'(zu3_q);
      d4_q[LANE_V_TZ] <= zz3_q;
      d4_q[LANE_V_RX] <= zz3_q;
      d4_q[LANE_V_RY] <= zz3_q;
      d4_q[LANE_V_RZ] <= 64'(zu3_q);
      n4_q[LANE_U_TX] <= 1'b0;
      n4_q[LANE_U_TZ] <= xpos3_q;
      n4_q[LANE_U_RX] <= (xneg3_q == yneg3_q);
      n4_q[LANE_U_RY] <= 1'b0;
      n4_q[LANE_U_RZ] <= ypos3_q;
      n4_q[LANE_V_TY] <= 1'b0;
      n4_q[LANE_V_TZ] <= ypos3_q;
      n4_q[LANE_V_RX] <= 1'b1;
      n4_q[LANE_V_RY] <= (xneg3_q != yneg3_q);
      n4_q[LANE_V_RZ] <= xneg3_q;
    end
  end

  // Stage 5: focal length times numerator, as two 32x32 partial products.
  logic    v5_q, ok5_q;
  word64_t plo5_q [NUM_LANES];
  word64_t phi5_q [NUM_LANES];
  word64_t d5_q   [NUM_LANES];
  logic    n5_q   [NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok5_q <= ok4_q;
      for (int l = 0; l < NUM_LANES; l++) begin
        plo5_q[l] <= 64'((l < LANE_V_TY) ? focal_x_q : focal_y_q) * 64'(m4_q[l][31:0]);
        phi5_q[l] <= 64'((l < LANE_V_TY) ? focal_x_q : focal_y_q) * 64'(m4_q[l][63:32]);
        d5_q[l]   <= d4_q[l];
        n5_q[l]   <= n4_q[l];
      end
    end
  end

  // Stage 6: combine the partial products into the 96-bit dividend.
  logic    v6_q, ok6_q;
  word96_t num6_q [NUM_LANES];
  word64_t d6_q   [NUM_LANES];
  logic    n6_q   [NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok6_q <= ok5_q;
      for (int l = 0; l < NUM_LANES; l++) begin
        num6_q[l] <= 96'(plo5_q[l]) + {phi5_q[l], 32'd0};
        d6_q[l]   <= d5_q[l];
        n6_q[l]   <= n5_q[l];
      end
    end
  end

  // Divider stage 0: overflow check and partial remainder setup.
  // A quotient of 2^32 or more saturates in every lane.
  logic    dv_q  [QUO_BITS+1];
  logic    dok_q [QUO_BITS+1];
  word64_t dr_q  [QUO_BITS+1][NUM_LANES];
  word64_t dd_q  [QUO_BITS+1][NUM_LANES];
  word32_t dn_q  [QUO_BITS+1][NUM_LANES];
  word32_t dq_q  [QUO_BITS+1][NUM_LANES];
  logic    dovf_q[QUO_BITS+1][NUM_LANES];
  logic    dneg_q[QUO_BITS+1][NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dok_q[0] <= ok6_q;
      for (int l = 0; l < NUM_LANES; l++) begin
        dovf_q[0][l] <= (num6_q[l][95:32] >= d6_q[l]);
        dr_q[0][l]   <= num6_q[l][95:32];
        dn_q[0][l]   <= num6_q[l][31:0];
        dq_q[0][l]   <= '0;
        dd_q[0][l]   <= d6_q[l];
        dneg_q[0][l] <= n6_q[l];
      end
    end
  end

  // Restoring divider: one quotient bit per stage.
  for (genvar s = 1; s <= QUO_BITS; s++) begin : g_div
    word64_t trial [NUM_LANES];
    logic    ge    [NUM_LANES];

    always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trial[l] = {dr_q[s-1][l][62:0], dn_q[s-1][l][31]};
        ge[l]    = (trial[l] >= dd_q[s-1][l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else if (en) begin
        dv_q[s] <= dv_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dok_q[s] <= dok_q[s-1];
        for (int l = 0; l < NUM_LANES; l++) begin
          dr_q[s][l]   <= ge[l] ? (trial[l] - dd_q[s-1][l]) : trial[l];
          dn_q[s][l]   <= {dn_q[s-1][l][30:0], 1'b0};
          dq_q[s][l]   <= {dq_q[s-1][l][30:0], ge[l]};
          dd_q[s][l]   <= dd_q[s-1][l];
          dovf_q[s][l] <= dovf_q[s-1][l];
          dneg_q[s][l] <= dneg_q[s-1][l];
        end
      end
    end
  end

  // Output stage: sign, saturation and zeroing of invalid points.
  word32_t sat [NUM_LANES];
  word32_t res_q [NUM_LANES];
  logic    out_vld_q, res_ok_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (!dok_q[QUO_BITS]) begin
        sat[l] = '0;
      end else if (dneg_q[QUO_BITS][l]) begin
        if (dovf_q[QUO_BITS][l] || (dq_q[QUO_BITS][l] > SAT_NEG)) begin
          sat[l] = SAT_NEG;
        end else begin
          sat[l] = 32'(-dq_q[QUO_BITS][l]);
        end
      end else begin
        if (dovf_q[QUO_BITS][l] || dq_q[QUO_BITS][l][31]) begin
          sat[l] = SAT_POS;
        end else begin
          sat[l] = dq_q[QUO_BITS][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_q[QUO_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_ok_q <= dok_q[QUO_BITS];
      for (int l = 0; l < NUM_LANES; l++) begin
        res_q[l] <= sat[l];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign valid_res_o = res_ok_q;
  assign j_u_tx_o    = res_q[LANE_U_TX];
  assign j_u_tz_o    = res_q[LANE_U_TZ];
  assign j_u_rx_o    = res_q[LANE_U_RX];
  assign j_u_ry_o    = res_q[LANE_U_RY];
  assign j_u_rz_o    = res_q[LANE_U_RZ];
  assign j_v_ty_o    = res_q[LANE_V_TY];
  assign j_v_tz_o    = res_q[LANE_V_TZ];
  assign j_v_rx_o    = res_q[LANE_V_RX];
  assign j_v_ry_o    = res_q[LANE_V_RY];
  assign j_v_rz_o    = res_q[LANE_V_RZ];

  // Assertions.
  // The input side is only held back by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // An invalid point yields all-zero entries; four of the ten entries are checked.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (j_u_tx_o == '0 && j_u_ry_o == '0 && j_v_ty_o == '0 && j_v_rx_o == '0))
    else $error("invalid point with non-zero Jacobian entries");

  // Entries that are positive or negative by construction keep their sign.
  a_entry_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      (!j_u_tx_o[31] && !j_u_ry_o[31] && !j_v_ty_o[31] &&
       (j_v_rx_o[31] || j_v_rx_o == '0)))
    else $error("Jacobian entry with wrong sign");

  // A stalled pipeline does not advance a result into the output register.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

FILE: tb/se3_projection_jacobian_core_test.sv
// ----------------------------------------------------------------------------
// se3_projection_jacobian_core_test: self-checking bench of the Jacobian core
// Stores points in the per-pixel store, requests Jacobians of stored pixels
// and checks every result transaction field by field against a bit-exact
// predictor, under random sender gaps, receiver stalls and focal settings.
// ----------------------------------------------------------------------------
`default_nettype none

module se3_projection_jacobian_core_test
  import se3pj_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 50;
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_JACOBIAN = 1'b1;

  // One input transaction.
  typedef struct {
    logic        func;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } pixel_op_t;

  // One result transaction, entries in lane order of the package.
  typedef struct {
    logic        ok;
    logic [31:0] lane[NUM_LANES];
  } jacobian_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [5:0]  pixel_col_i = '0;
  logic [5:0]  pixel_row_i = '0;
  logic [31:0] point_x_i = '0;
  logic [31:0] point_y_i = '0;
  logic [31:0] point_z_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valid_res_o;
  logic [31:0] j_u_tx_o, j_u_tz_o, j_u_rx_o, j_u_ry_o, j_u_rz_o;
  logic [31:0] j_v_ty_o, j_v_tz_o, j_v_rx_o, j_v_ry_o, j_v_rz_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = REG_FOCAL_X;
  logic [31:0] cfg_data_i = '0;

  se3_projection_jacobian_core u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .func_i, .pixel_col_i, .pixel_row_i,
    .point_x_i, .point_y_i, .point_z_i,
    .out_valid_o, .out_stall_i, .valid_res_o,
    .j_u_tx_o, .j_u_tz_o, .j_u_rx_o, .j_u_ry_o, .j_u_rz_o,
    .j_v_ty_o, .j_v_tz_o, .j_v_rx_o, .j_v_ry_o, .j_v_rz_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bench copy of the block's state.
  logic [31:0] focal_x_q = FOCAL_RESET;
  logic [31:0] focal_y_q = FOCAL_RESET;
  logic [31:0] cell_x[4096];
  logic [31:0] cell_y[4096];
  logic [31:0] cell_z[4096];
  bit          cell_written[4096];
  int unsigned written_cells[$];

  pixel_op_t   pending_ops[$];
  jacobian_t   expected_jacobians[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned ops_accepted = 0;

  // Truncated (f * m) / d with sign and 32-bit saturation.
  function automatic logic [31:0] jac_term(logic [31:0] f, logic [63:0] m,
                                           logic [63:0] d, bit neg);
    logic [127:0] q;
    q = ({96'd0, f} * {64'd0, m}) / {64'd0, d};
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Jacobian of the point stored at one pixel under the current focal lengths.
  function automatic jacobian_t predict_jacobian(int unsigned pix);
    jacobian_t   j;
    logic signed [31:0] x, y, z;
    logic [63:0] ax, ay, zu, zz;
    x = cell_x[pix];
    y = cell_y[pix];
    z = cell_z[pix];
    j.ok = 1'b0;
    foreach (j.lane[k]) j.lane[k] = '0;
    if (z <= 0) return j;
    ax = (x < 0) ? 64'd0 - {{32{x[31]}}, x} : {32'd0, x};
    ay = (y < 0) ? 64'd0 - {{32{y[31]}}, y} : {32'd0, y};
    zu = {32'd0, z};
    zz = zu * zu;
    j.ok = 1'b1;
    j.lane[LANE_U_TX] = jac_term(focal_x_q, Q16_ONE, zu, 1'b0);
    j.lane[LANE_U_TZ] = jac_term(focal_x_q, ax << 16, zz, x > 0);
    j.lane[LANE_U_RX] = jac_term(focal_x_q, ax * ay, zz, (x < 0) == (y < 0));
    j.lane[LANE_U_RY] = jac_term(focal_x_q, zz + ax * ax, zz, 1'b0);
    j.lane[LANE_U_RZ] = jac_term(focal_x_q, ay, zu, y > 0);
    j.lane[LANE_V_TY] = jac_term(focal_y_q, Q16_ONE, zu, 1'b0);
    j.lane[LANE_V_TZ] = jac_term(focal_y_q, ay << 16, zz, y > 0);
    j.lane[LANE_V_RX] = jac_term(focal_y_q, zz + ay * ay, zz, 1'b1);
    j.lane[LANE_V_RY] = jac_term(focal_y_q, ax * ay, zz, (x < 0) != (y < 0));
    j.lane[LANE_V_RZ] = jac_term(focal_y_q, ax, zu, x < 0);
    return j;
  endfunction

  // Driver: presents queued transactions, updates the bench state on accept.
  always @(posedge clk_i) begin
    pixel_op_t op;
    int unsigned pix;
    logic next_valid;
    next_valid = in_valid_i;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      op = pending_ops.pop_front();
      pix = {20'd0, op.row, op.col};
      ops_accepted++;
      if (op.func == FUNC_STORE) begin
        cell_x[pix] = op.px;
        cell_y[pix] = op.py;
        cell_z[pix] = op.pz;
        if (!cell_written[pix]) begin
          cell_written[pix] = 1'b1;
          written_cells.push_back(pix);
        end
      end else begin
        expected_jacobians.push_back(predict_jacobian(pix));
      end
      next_valid = 1'b0;
    end
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      next_valid = pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (next_valid) begin
        func_i      <= pending_ops[0].func;
        pixel_col_i <= pending_ops[0].col;
        pixel_row_i <= pending_ops[0].row;
        point_x_i   <= pending_ops[0].px;
        point_y_i   <= pending_ops[0].py;
        point_z_i   <= pending_ops[0].pz;
      end
    end
    in_valid_i <= next_valid;
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && $urandom_range(99) < recv_stall_pct;
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    jacobian_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ok = valid_res_o;
      got.lane[LANE_U_TX] = j_u_tx_o;
      got.lane[LANE_U_TZ] = j_u_tz_o;
      got.lane[LANE_U_RX] = j_u_rx_o;
      got.lane[LANE_U_RY] = j_u_ry_o;
      got.lane[LANE_U_RZ] = j_u_rz_o;
      got.lane[LANE_V_TY] = j_v_ty_o;
      got.lane[LANE_V_TZ] = j_v_tz_o;
      got.lane[LANE_V_RX] = j_v_rx_o;
      got.lane[LANE_V_RY] = j_v_ry_o;
      got.lane[LANE_V_RZ] = j_v_rz_o;
      results_seen++;
      if (!got.ok) invalid_seen++;
      if (expected_jacobians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction");
      end else begin
        want = expected_jacobians.pop_front();
        if (got.ok !== want.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d valid_res expected %b got %b",
                     results_seen, want.ok, got.ok);
        end
        foreach (want.lane[k]) begin
          if (got.lane[k] !== want.lane[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d lane %0d expected %h got %h",
                       results_seen, k, want.lane[k], got.lane[k]);
          end
        end
      end
    end
  end

  // Random coordinate: mostly moderate magnitudes, sometimes any code.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  // Random depth: spans negative, zero, tiny and large values.
  function automatic logic [31:0] rand_depth();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'd0 - $urandom_range(32'h0100_0000);
      2: return '0;
      3: return $urandom_range(1, 32'h0000_0100);
      default: return $urandom_range(32'h0000_4000, 32'h0100_0000);
    endcase
  endfunction

  task automatic queue_store(logic [5:0] col, logic [5:0] row,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    pixel_op_t op;
    op = '{FUNC_STORE, col, row, px, py, pz};
    pending_ops.push_back(op);
  endtask

  task automatic queue_jacobian(logic [5:0] col, logic [5:0] row);
    pixel_op_t op;
    op = '{FUNC_JACOBIAN, col, row, $urandom, $urandom, $urandom};
    pending_ops.push_back(op);
  endtask

  // Random traffic; Jacobians only address pixels already queued for a store.
  task automatic queue_random(int unsigned count);
    bit known[4096];
    int unsigned cells[$];
    int unsigned pix;
    foreach (written_cells[i]) begin
      known[written_cells[i]] = 1'b1;
      cells.push_back(written_cells[i]);
    end
    for (int i = 0; i < count; i++) begin
      if (cells.size() == 0 || $urandom_range(99) < 40) begin
        pix = $urandom_range(4095);
        queue_store(pix[5:0], pix[11:6], rand_coord(), rand_coord(), rand_depth());
        if (!known[pix]) begin
          known[pix] = 1'b1;
          cells.push_back(pix);
        end
      end else begin
        pix = cells[$urandom_range(cells.size() - 1)];
        queue_jacobian(pix[5:0], pix[11:6]);
      end
    end
  endtask

  // Waits until every queued transaction is in and every result is out.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || expected_jacobians.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_focal(logic index, logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == REG_FOCAL_X) focal_x_q = value;
    else focal_y_q = value;
  endtask

  // Stimulus sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 31;
    recv_stall_pct = 85;

    // Directed: corners, extreme coordinates and depths, non-positive depths.
    queue_store(6'd0, 6'd0, 32'h0001_0000, 32'hFFFE_0000, 32'h0004_0000);
    queue_store(6'd63, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    queue_store(6'd63, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_store(6'd0, 6'd63, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_store(6'd21, 6'd42, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_FFFF);
    queue_store(6'd42, 6'd21, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_store(6'd1, 6'd1, 32'hFFFF_8000, 32'h0000_8000, 32'h0001_0000);
    queue_jacobian(6'd0, 6'd0);
    queue_jacobian(6'd63, 6'd63);
    queue_jacobian(6'd63, 6'd0);
    queue_jacobian(6'd0, 6'd63);
    queue_jacobian(6'd21, 6'd42);
    queue_jacobian(6'd42, 6'd21);
    queue_jacobian(6'd1, 6'd1);
    // Store then read back at once, then overwrite the same pixel.
    queue_store(6'd5, 6'd9, 32'h0000_4000, 32'hFFFF_C000, 32'h0000_2000);
    queue_jacobian(6'd5, 6'd9);
    queue_store(6'd5, 6'd9, 32'h1234_5678, 32'h8765_4321, 32'h0002_0000);
    queue_jacobian(6'd5, 6'd9);
    queue_jacobian(6'd5, 6'd9);
    wait_idle();

    // Phase with zero and full-scale focal lengths.
    write_focal(REG_FOCAL_X, 32'h0000_0000);
    write_focal(REG_FOCAL_Y, 32'hFFFF_FFFF);
    queue_random(340);
    wait_idle();

    // Receiver mostly ready, sender often idle.
    send_idle_pct = 85;
    recv_stall_pct = 31;
    write_focal(REG_FOCAL_X, 32'hFFFF_FFFF);
    write_focal(REG_FOCAL_Y, 32'h0000_0001);
    queue_random(340);
    wait_idle();

    // Full rate with ordinary focal lengths.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_focal(REG_FOCAL_X, $urandom_range(32'h0064_0000, 32'h03E8_0000));
    write_focal(REG_FOCAL_Y, FOCAL_RESET);
    queue_random(350);
    wait_idle();

    $display("Covered %0d transactions, %0d results (%0d with depth not positive),",
             ops_accepted, results_seen, invalid_seen);
    $display("four focal settings and three sender/receiver idle patterns.");
    if (mismatches == 0 && expected_jacobians.size() == 0) begin
      $display("se3_projection_jacobian_core_test passed");
    end else begin
      $display("se3_projection_jacobian_core_test failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("se3_projection_jacobian_core_test failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: se3_projection_jacobian_core.f
sv/se3pj_pkg.sv
sv/se3_projection_jacobian_core.sv
tb/se3_projection_jacobian_core_test.sv
